@@ rtl/core/haoc_pkg.sv @@
// Package for the hearing aid output chain: register indexes, fixed widths and constants.
// No dependencies; the divider and the output chain unit import it.
package haoc_pkg;

  localparam int CfgIdxW   = 4;
  localparam int CfgDataW  = 24;
  localparam int GainW     = 16;
  localparam int CoefW     = 24;
  localparam int EnW       = 4;
  localparam int HistW     = 20;
  localparam int EnvW      = 24;
  localparam int OutW      = 17;
  localparam int InW       = 16;
  localparam int GainFrac  = 12;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIC_GAIN = 4'd0,
    REG_AMB_GAIN = 4'd1,
    REG_FEATURES = 4'd2,
    REG_COEF_B0  = 4'd3,
    REG_COEF_B1  = 4'd4,
    REG_COEF_B2  = 4'd5,
    REG_COEF_A1  = 4'd6,
    REG_COEF_A2  = 4'd7
  } cfg_reg_t;

  localparam int EnHp   = 0;
  localparam int EnShlf = 1;
  localparam int EnLim  = 2;
  localparam int EnMute = 3;

  // handshake between sequencer and divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/core/haoc_div.sv @@
// Restoring divider of the output chain, one quotient bit per cycle.
// Depends on haoc_pkg.
module haoc_div #(
  parameter int NumW = 64,
  parameter int DenW = 25
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  haoc_pkg::div_req_t     req,
  input  logic [NumW-1:0]        num,
  input  logic [DenW-1:0]        den,
  output haoc_pkg::div_stat_t    stat,
  output logic [NumW-1:0]        quo
);
  import haoc_pkg::*;

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q_r, q_nxt;
  logic [DenW:0]   rem_r, rem_nxt;
  logic [DenW-1:0] den_r, den_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [DenW:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DenW-1:0], q_r[NumW-1]};
    if (req.start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CntW'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = q_r;

endmodule

@@ rtl/core/hearing_aid_output_chain_unit.sv @@
// Hearing aid output chain: high-pass, shelf biquad, gains, limiter or clamp, or mute.
// Muted items skip processing; the limiter above the lower knee runs the 64-step divider,
// and the sequencer drives the single 29x26 multiplier for every product.
// One item at a time: in_tready is high only when the sequencer is idle and the output is free,
// so the next item is not taken before the result has been accepted.
// Reset (rst_n low, synchronous) restores register defaults and clears all filter state.
// Depends on haoc_pkg and haoc_div.
module hearing_aid_output_chain_unit #(
  parameter int SAMPLE_FRAC_BITS = 15,
  parameter int COEF_FRAC_BITS   = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [15:0] mic_sample
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,  // [16:0] out_sample, rest zero
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [haoc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [haoc_pkg::CfgDataW-1:0] cfg_data
);
  import haoc_pkg::*;

  localparam int F = SAMPLE_FRAC_BITS;
  localparam int C = COEF_FRAC_BITS;
  // constants in coefficient units
  localparam longint HpPole  = ((longint'(95) << C) + 50) / 100;
  localparam longint EnvAtk  = ((longint'(5) << C) + 50) / 100;
  localparam longint EnvRel  = ((longint'(5) << C) + 5000) / 10000;
  // sample domain constants
  localparam longint ClampLim = ((longint'(11) << F) + 5) / 10;
  localparam longint LimTh    = (longint'(3) << F) / 4;
  localparam longint KneeLo   = ((longint'(27) << F) + 20) / 40;
  localparam longint KneeHi   = ((longint'(33) << F) + 20) / 40;
  localparam longint KneeDen  = longint'(3) << F;
  localparam longint OutLim   = longint'(2) << F;
  localparam int     AccW     = 64;
  // divide by three as a reciprocal multiply, exact for operands below 2^24
  localparam int     Div3Sh   = 25;
  localparam longint Div3Mul  = ((longint'(1) << Div3Sh) + 1) / 3;

  // multiplier operands
  localparam int MaW = 29;
  localparam int MbW = 26;

  typedef enum logic [4:0] {
    S_IDLE, S_HP, S_HP_FIN, S_SH0, S_SH1, S_SH2, S_SH3, S_SH4, S_SH_FIN,
    S_G0, S_G1, S_MIX, S_ENV, S_ENV_FIN, S_KNEE, S_KNEE_R, S_DIV, S_DIV_W,
    S_LIM_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [GainW-1:0]        mic_gain_r, amb_gain_r;
  logic [EnW-1:0]          en_r;
  logic signed [CoefW-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;

  // filter state
  logic signed [InW-1:0]   hp_in_r;
  logic signed [HistW-1:0] hp_out_r, x1_r, x2_r, y1_r, y2_r;
  logic [EnvW-1:0]         env_r, env_nxt;

  // working registers
  logic signed [InW-1:0]   raw_r, raw_nxt;
  logic signed [HistW-1:0] s_r, s_nxt;
  logic signed [AccW-1:0]  acc_r, acc_nxt;
  logic signed [AccW-1:0]  prod_r;
  logic signed [MaW-1:0]   ma;
  logic signed [MbW-1:0]   mb;
  logic signed [AccW-1:0]  mix_r, mix_nxt;
  logic [EnvW-1:0]         mag_r, mag_nxt;
  logic [EnvW:0]           numk_r, numk_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [OutW-1:0]  out_r, out_nxt;
  logic                    ovld_r, ovld_nxt;

  div_req_t        dreq;
  div_stat_t       dstat;
  logic [AccW-1:0] dnum, dquo;
  logic [EnvW:0]   dden;

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod_r <= AccW'(ma * mb);
  end

  function automatic logic signed [AccW-1:0] rshr(input logic signed [AccW-1:0] v,
                                                  input int s);
    logic signed [AccW-1:0] t;
    t = v + (AccW'(1) <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic logic signed [HistW-1:0] sat_h(input logic signed [AccW-1:0] v);
    if (v > AccW'((longint'(1) << (HistW - 1)) - 1))
      return {1'b0, {(HistW-1){1'b1}}};
    else if (v < -AccW'(longint'(1) << (HistW - 1)))
      return {1'b1, {(HistW-1){1'b0}}};
    else
      return v[HistW-1:0];
  endfunction

  function automatic logic signed [OutW-1:0] clip_o(input logic signed [AccW-1:0] v,
                                                    input longint lo, input longint hi);
    if (v > AccW'(hi)) return OutW'(hi);
    else if (v < AccW'(lo)) return OutW'(lo);
    else return v[OutW-1:0];
  endfunction

  logic signed [AccW-1:0] tmp, envd;

  always_comb begin
    state_nxt = state_r;
    raw_nxt   = raw_r;
    s_nxt     = s_r;
    acc_nxt   = acc_r;
    mix_nxt   = mix_r;
    mag_nxt   = mag_r;
    numk_nxt  = numk_r;
    neg_nxt   = neg_r;
    env_nxt   = env_r;
    out_nxt   = out_r;
    ovld_nxt  = ovld_r;
    ma        = '0;
    mb        = '0;
    dreq.start = 1'b0;
    dnum      = '0;
    dden      = '0;
    tmp       = '0;
    envd      = '0;
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && !ovld_r) begin
          raw_nxt = in_tdata;
          s_nxt   = HistW'($signed(in_tdata));
          acc_nxt = '0;
          if (en_r[EnMute]) begin
            out_nxt   = '0;
            state_nxt = S_OUT;
          end else if (en_r[EnHp]) begin
            state_nxt = S_HP;
          end else if (en_r[EnShlf]) begin
            state_nxt = S_SH0;
          end else begin
            state_nxt = S_G0;
          end
        end
      end
      S_HP: begin
        ma = MaW'(HpPole); mb = MbW'(hp_out_r);
        state_nxt = S_HP_FIN;
      end
      S_HP_FIN: begin
        tmp = AccW'(s_r) - AccW'(hp_in_r) + rshr(prod_r, C);
        s_nxt = sat_h(tmp);
        state_nxt = en_r[EnShlf] ? S_SH0 : S_G0;
      end
      S_SH0: begin
        ma = MaW'(b0_r); mb = MbW'(s_r); state_nxt = S_SH1;
      end
      S_SH1: begin
        acc_nxt = prod_r; ma = MaW'(b1_r); mb = MbW'(x1_r); state_nxt = S_SH2;
      end
      S_SH2: begin
        acc_nxt = acc_r + prod_r; ma = MaW'(b2_r); mb = MbW'(x2_r); state_nxt = S_SH3;
      end
      S_SH3: begin
        acc_nxt = acc_r + prod_r; ma = -MaW'(a1_r); mb = MbW'(y1_r); state_nxt = S_SH4;
      end
      S_SH4: begin
        acc_nxt = acc_r + prod_r; ma = -MaW'(a2_r); mb = MbW'(y2_r);
        state_nxt = S_SH_FIN;
      end
      S_SH_FIN: begin
        acc_nxt = acc_r + prod_r;
        state_nxt = S_G0;
      end
      S_G0: begin
        // apply the biquad result first if the shelf ran
        if (en_r[EnShlf]) s_nxt = sat_h(rshr(acc_r, C));
        acc_nxt = '0;
        state_nxt = S_G1;
      end
      S_G1: begin
        ma = MaW'(s_r); mb = MbW'({1'b0, mic_gain_r});
        state_nxt = S_MIX;
      end
      S_MIX: begin
        // first pass: mic product arrives, launch ambient product
        if (acc_r != AccW'(1)) begin
          mix_nxt = rshr(prod_r, GainFrac);
          ma = MaW'(raw_r); mb = MbW'({1'b0, amb_gain_r});
          acc_nxt = AccW'(1);
        end else begin
          mix_nxt = mix_r + rshr(prod_r, GainFrac);
          tmp = mix_r + rshr(prod_r, GainFrac);
          acc_nxt = '0;
          if (en_r[EnLim]) state_nxt = S_ENV;
          else begin
            out_nxt = clip_o(tmp, -ClampLim, ClampLim);
            state_nxt = S_OUT;
          end
        end
      end
      S_ENV: begin
        neg_nxt = mix_r[AccW-1];
        tmp = mix_r[AccW-1] ? -mix_r : mix_r;
        mag_nxt = (tmp > AccW'((longint'(1) << EnvW) - 1)) ? '1 : tmp[EnvW-1:0];
        state_nxt = S_ENV_FIN;
        acc_nxt = '0;
      end
      S_ENV_FIN: begin
        if (acc_r == '0) begin
          ma = MaW'($signed({1'b0, mag_r}) - $signed({1'b0, env_r}));
          mb = (mag_r > env_r) ? MbW'(EnvAtk) : MbW'(EnvRel);
          acc_nxt = AccW'(1);
        end else begin
          tmp = AccW'({1'b0, env_r}) + rshr(prod_r, C);
          if (tmp < 0) env_nxt = '0;
          else if (tmp > AccW'((longint'(1) << EnvW) - 1)) env_nxt = '1;
          else env_nxt = tmp[EnvW-1:0];
          acc_nxt = '0;
          state_nxt = S_KNEE;
        end
      end
      S_KNEE: begin
        tmp = mix_r[AccW-1] ? -mix_r : mix_r;
        if (AccW'(env_r) <= AccW'(KneeLo)) begin
          out_nxt = clip_o(mix_r, -OutLim, OutLim - 1);
          state_nxt = S_OUT;
        end else if (AccW'(env_r) >= AccW'(KneeHi)) begin
          numk_nxt = (EnvW+1)'(LimTh);
          state_nxt = S_DIV;
        end else begin
          ma = MaW'(AccW'(env_r) - AccW'(KneeLo));
          mb = MbW'(AccW'(env_r) - AccW'(KneeLo));
          state_nxt = S_KNEE_R;
          acc_nxt = '0;
        end
      end
      S_KNEE_R: begin
        // r = (10 d^2 + den/2) / den: drop the 2^F factor, then divide by three
        if (acc_r == '0) begin
          tmp = (prod_r * 10 + AccW'(KneeDen / 2)) >>> F;
          ma = MaW'(tmp);
          mb = MbW'(Div3Mul);
          acc_nxt = AccW'(1);
        end else begin
          envd = AccW'(env_r) - (prod_r >>> Div3Sh);
          numk_nxt = (envd < 0) ? '0 : envd[EnvW:0];
          acc_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        ma = MaW'(mix_r[AccW-1] ? -mix_r : mix_r);
        mb = MbW'(numk_r);
        state_nxt = S_DIV_W;
        acc_nxt = '0;
      end
      S_DIV_W: begin
        if (acc_r == '0) begin
          dreq.start = 1'b1;
          dnum = AccW'(prod_r + AccW'(env_r >> 1));
          dden = {1'b0, env_r};
          acc_nxt = AccW'(1);
        end else if (dstat.done) begin
          acc_nxt = '0;
          state_nxt = S_LIM_FIN;
        end
      end
      S_LIM_FIN: begin
        tmp = neg_r ? -$signed(dquo) : $signed(dquo);
        out_nxt = clip_o(tmp, -OutLim, OutLim - 1);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovld_r || out_tready) begin
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  haoc_div #(.NumW(AccW), .DenW(EnvW + 1)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .num  (dnum),
    .den  (dden),
    .stat (dstat),
    .quo  (dquo)
  );

  // state updates committed at the points where each stage finishes
  always_ff @(posedge clk) begin
    raw_r  <= raw_nxt;
    s_r    <= s_nxt;
    acc_r  <= acc_nxt;
    mix_r  <= mix_nxt;
    mag_r  <= mag_nxt;
    numk_r <= numk_nxt;
    neg_r  <= neg_nxt;
    out_r  <= out_nxt;
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ovld_r     <= 1'b0;
      mic_gain_r <= 16'd4096;
      amb_gain_r <= '0;
      en_r       <= '0;
      b0_r       <= 24'sd2372833;
      b1_r       <= -24'sd3911503;
      b2_r       <= 24'sd1738975;
      a1_r       <= -24'sd1496916;
      a2_r       <= 24'sd648649;
      hp_in_r    <= '0;
      hp_out_r   <= '0;
      x1_r <= '0; x2_r <= '0; y1_r <= '0; y2_r <= '0;
      env_r      <= '0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
      env_r   <= env_nxt;
      if (state_r == S_HP_FIN) begin
        hp_in_r  <= raw_r;
        hp_out_r <= s_nxt;
      end
      if (state_r == S_G0 && en_r[EnShlf]) begin
        x2_r <= x1_r; x1_r <= s_r;
        y2_r <= y1_r; y1_r <= s_nxt;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MIC_GAIN: mic_gain_r <= cfg_data[GainW-1:0];
          REG_AMB_GAIN: amb_gain_r <= cfg_data[GainW-1:0];
          REG_FEATURES: en_r       <= cfg_data[EnW-1:0];
          REG_COEF_B0:  b0_r       <= cfg_data;
          REG_COEF_B1:  b1_r       <= cfg_data;
          REG_COEF_B2:  b2_r       <= cfg_data;
          REG_COEF_A1:  a1_r       <= cfg_data;
          REG_COEF_A2:  a2_r       <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE) && !ovld_r;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ovld_r;
  assign out_tdata  = {{(24-OutW){1'b0}}, out_r};

endmodule

@@ rtl/core/haoc_checker.sv @@
// Port-level checker for the hearing aid output chain, bound to the top level.
// Depends on hearing_aid_output_chain_unit.
module haoc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // one item at a time: no accept while a result is pending
  a_no_in_when_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken with result pending");

  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:17] == 7'd0) else $error("pad bits set");

  // accept is followed by busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("ready after accept");

endmodule

bind hearing_aid_output_chain_unit haoc_checker u_haoc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
